// ----- rtl/u8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: field widths, the replacement code point,
// the queue depth default and the command item passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

   localparam int unsigned BYTE_WIDTH    = 8;
   localparam int unsigned CP_WIDTH      = 21;
   localparam int unsigned REP_WIDTH     = 2;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

   // One decoded byte: rep_count replacement results, then an optional value
   typedef struct packed {
      logic [REP_WIDTH-1:0] rep_count;
      logic                 has_value;
      logic [CP_WIDTH-1:0]  value;
   } cmd_type;

endpackage

// ----- rtl/utf8_stream_decoder_core.sv -----
// Top level of the UTF-8 stream decoder: front, command queue and back.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back.
`timescale 1ns / 1ps
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready  | req_in_byte[7:0], req_end_of_string
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_code_point[20:0], rsp_last_of_run
//
// A byte is classified as it is accepted; a byte with no result is not queued.
// The back gives one result per cycle while rsp_ready is high, and holds each byte until all its results are taken.
// The queue (Depth entries) lets bytes keep coming while the back stalls or plays out
// a run of replacements; req_ready falls only when the queue is full.
// Synchronous reset closes any open sequence and empties queue and output.

module utf8_stream_decoder_core #(
   parameter int unsigned Depth = u8sd_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [u8sd_pkg::BYTE_WIDTH-1:0] req_in_byte,
   input  logic                          req_end_of_string,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8sd_pkg::CP_WIDTH-1:0] rsp_code_point,
   output logic                          rsp_last_of_run
);

   logic              accept, push, not_full, pop, head_valid;
   u8sd_pkg::cmd_type push_cmd, head_cmd;

   assign req_ready = not_full;
   assign accept    = req_valid && not_full;

   u8sd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .push          (push),
      .cmd           (push_cmd)
   );

   u8sd_queue #(
      .Depth (Depth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .not_full   (not_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   u8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/u8sd_front.sv -----
// Front of the UTF-8 stream decoder: holds the open-sequence state, classifies
// each accepted byte and turns it into at most one command item for the back.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [u8sd_pkg::BYTE_WIDTH-1:0] in_byte,
   input  logic                          end_of_string,
   output logic                          push,
   output u8sd_pkg::cmd_type             cmd
);

   logic [u8sd_pkg::CP_WIDTH-1:0]  gathered_ff, gathered_in;
   logic [1:0]                     need_ff, need_in;
   logic [1:0]                     taken_ff, taken_in;

   logic                           is_cont;
   logic [u8sd_pkg::CP_WIDTH-1:0]  cont_bits;
   logic [1:0]                     need_dec;

   // fresh decode of the byte as if no sequence were open
   logic                           fr_value;
   logic [u8sd_pkg::CP_WIDTH-1:0]  fr_cp;
   logic                           fr_open;
   logic [1:0]                     fr_need;
   logic [u8sd_pkg::CP_WIDTH-1:0]  fr_payload;

   assign is_cont   = (in_byte[7:6] == 2'b10);
   assign cont_bits = {gathered_ff[u8sd_pkg::CP_WIDTH-7:0], in_byte[5:0]};
   assign need_dec  = need_ff - 2'd1;

   // lead byte classification
   always_comb begin
      fr_value   = 1'b1;
      fr_cp      = u8sd_pkg::REPLACEMENT_CHAR;
      fr_open    = 1'b0;
      fr_need    = 2'd0;
      fr_payload = '0;
      priority if (in_byte[7] == 1'b0) begin
         fr_cp = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
         fr_need    = 2'd1;
         fr_payload = {16'd0, in_byte[4:0]};
         fr_open    = 1'b1;
      end else if (in_byte[7:4] == 4'b1110) begin
         fr_need    = 2'd2;
         fr_payload = {17'd0, in_byte[3:0]};
         fr_open    = 1'b1;
      end else if (in_byte[7:3] == 5'b11110) begin
         fr_need    = 2'd3;
         fr_payload = {18'd0, in_byte[2:0]};
         fr_open    = 1'b1;
      end else begin
         fr_cp = u8sd_pkg::REPLACEMENT_CHAR;
      end
      // a lead byte that ends the string is malformed on its own
      if (fr_open) begin
         if (end_of_string) begin
            fr_open = 1'b0;
         end else begin
            fr_value = 1'b0;
         end
      end
   end

   // command and next state
   always_comb begin
      gathered_in   = gathered_ff;
      need_in       = need_ff;
      taken_in      = taken_ff;
      cmd.rep_count = '0;
      cmd.has_value = 1'b0;
      cmd.value     = u8sd_pkg::REPLACEMENT_CHAR;
      if (need_ff != 2'd0 && is_cont) begin
         if (need_dec == 2'd0) begin
            cmd.has_value = 1'b1;
            cmd.value     = cont_bits;
            gathered_in   = '0;
            need_in       = 2'd0;
            taken_in      = 2'd0;
         end else if (end_of_string) begin
            // lead plus every continuation taken, this one included
            cmd.rep_count = taken_ff + 2'd2;
            gathered_in   = '0;
            need_in       = 2'd0;
            taken_in      = 2'd0;
         end else begin
            gathered_in = cont_bits;
            need_in     = need_dec;
            taken_in    = taken_ff + 2'd1;
         end
      end else begin
         // no open sequence, or a broken one: flush any open sequence, then decode the byte afresh
         if (need_ff != 2'd0) begin
            cmd.rep_count = taken_ff + 2'd1;
         end
         cmd.has_value = fr_value;
         cmd.value     = fr_cp;
         if (fr_open && !end_of_string) begin
            gathered_in = fr_payload;
            need_in     = fr_need;
         end else begin
            gathered_in = '0;
            need_in     = 2'd0;
         end
         taken_in = 2'd0;
      end
   end

   assign push = accept && ((cmd.rep_count != '0) || cmd.has_value);

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         gathered_ff <= '0;
         need_ff     <= 2'd0;
         taken_ff    <= 2'd0;
      end else if (accept) begin
         gathered_ff <= gathered_in;
         need_ff     <= need_in;
         taken_ff    <= taken_in;
      end
   end

endmodule

// ----- rtl/u8sd_queue.sv -----
// Command queue between front and back of the UTF-8 stream decoder.
// Small register FIFO; depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_queue #(
   parameter int unsigned Depth = u8sd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8sd_pkg::cmd_type push_cmd,
   output logic              not_full,
   input  logic              pop,
   output logic              head_valid,
   output u8sd_pkg::cmd_type head_cmd
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   u8sd_pkg::cmd_type       entry_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign not_full   = (count_ff != CountWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/u8sd_back.sv -----
// Back of the UTF-8 stream decoder: takes command items from the queue and
// plays out their results one per cycle while rsp_ready is high, from a registered command.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  u8sd_pkg::cmd_type             head_cmd,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8sd_pkg::CP_WIDTH-1:0] rsp_code_point,
   output logic                          rsp_last_of_run
);

   u8sd_pkg::cmd_type cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic              take, last_result;

   assign last_result = (cur_ff.rep_count == '0) ||
                        ((cur_ff.rep_count == 2'd1) && !cur_ff.has_value);
   assign take        = cur_valid_ff && rsp_ready;
   assign pop         = head_valid && (!cur_valid_ff || (take && last_result));

   assign rsp_valid       = cur_valid_ff;
   assign rsp_last_of_run = last_result;
   assign rsp_code_point  = (cur_ff.rep_count != '0) ? u8sd_pkg::REPLACEMENT_CHAR
                                                     : cur_ff.value;

   // step through replacements, then the value; load the next item behind it
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (take) begin
         if (last_result) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_in.rep_count = cur_ff.rep_count - 2'd1;
         end
      end
      if (pop) begin
         cur_in       = head_cmd;
         cur_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
      cur_ff <= cur_in;
   end

endmodule

// ----- rtl/u8sd_checker.sv -----
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on u8sd_pkg and utf8_stream_decoder_core.
`timescale 1ns / 1ps

module u8sd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [u8sd_pkg::CP_WIDTH-1:0] rsp_code_point,
   input logic                          rsp_last_of_run
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_code_point) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // only the final result of a byte can carry a decoded value
   a_not_last_is_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_code_point == u8sd_pkg::REPLACEMENT_CHAR)
      else $error("non-final result is not a replacement");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // reset empties the queue, so the input is open again
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_code_point  (rsp_code_point),
   .rsp_last_of_run (rsp_last_of_run)
);
